FILE: sv/wo_pkg.sv
// wright omega approximation: shared constants, payload structs and helpers
// no dependencies; imported by wo_front, wo_div, the top level and the testbench
`default_nettype none

package wo_pkg;

	// fixed-point formats
	localparam int FRAC_BITS = 24;
	localparam int FRAC_SH   = 30 - FRAC_BITS;

	// divider geometry: 34-bit magnitude above FRAC_BITS zero bits, 32-bit divisor
	localparam int DVD_W = 34 + FRAC_BITS;
	localparam int DEN_W = 32;

	// decimal constants scaled to Q30, rounded to nearest on the magnitude
	localparam longint ONE30    = 64'sd1073741824;
	localparam longint DEC_ONE  = 64'sd1000000000;
	localparam longint HALF_DEC = 64'sd500000000;

	localparam longint C1_X1 = -((64'sd3684303660 * ONE30 + HALF_DEC) / DEC_ONE);
	localparam longint C1_X2 =  ((64'sd1972967392 * ONE30 + HALF_DEC) / DEC_ONE);
	localparam longint C1_A  =  ((64'sd9451797 * ONE30 + HALF_DEC) / DEC_ONE);
	localparam longint C1_B  =  ((64'sd112644641 * ONE30 + HALF_DEC) / DEC_ONE);
	localparam longint C1_C  =  ((64'sd445135389 * ONE30 + HALF_DEC) / DEC_ONE);
	localparam longint C1_D  =  ((64'sd583659668 * ONE30 + HALF_DEC) / DEC_ONE);

	localparam longint C2_X1 = -((64'sd3341459553 * ONE30 + HALF_DEC) / DEC_ONE);
	localparam longint C2_A  = -((64'sd1314293 * ONE30 + HALF_DEC) / DEC_ONE);
	localparam longint C2_B  =  ((64'sd47759314 * ONE30 + HALF_DEC) / DEC_ONE);
	localparam longint C2_C  =  ((64'sd363195266 * ONE30 + HALF_DEC) / DEC_ONE);
	localparam longint C2_D  =  ((64'sd631318346 * ONE30 + HALF_DEC) / DEC_ONE);

	localparam longint LG_K0 = -((64'sd2213475204 * ONE30 + HALF_DEC) / DEC_ONE);
	localparam longint LG_K1 =  ((64'sd3148297929 * ONE30 + HALF_DEC) / DEC_ONE);
	localparam longint LG_K2 = -((64'sd1098865286 * ONE30 + HALF_DEC) / DEC_ONE);
	localparam longint LG_K3 =  ((64'sd164042561 * ONE30 + HALF_DEC) / DEC_ONE);

	localparam longint PW_P1 = ((64'sd693147181 * ONE30 + HALF_DEC) / DEC_ONE);
	localparam longint PW_P2 = ((64'sd227411278 * ONE30 + HALF_DEC) / DEC_ONE);
	localparam longint PW_P3 = ((64'sd79441542 * ONE30 + HALF_DEC) / DEC_ONE);

	localparam longint K_LN2   = ((64'sd693147181 * ONE30 + HALF_DEC) / DEC_ONE);
	localparam longint K_LOG2E = ((64'sd1442695041 * ONE30 + HALF_DEC) / DEC_ONE);

	// thresholds rounded half up to the sample format
	localparam longint RND_SH   = 64'sd1 <<< (FRAC_SH - 1);
	localparam longint C1_X1_F  = (C1_X1 + RND_SH) >>> FRAC_SH;
	localparam longint C1_X2_F  = (C1_X2 + RND_SH) >>> FRAC_SH;
	localparam longint C2_X1_F  = (C2_X1 + RND_SH) >>> FRAC_SH;
	localparam longint EIGHT_F  = 64'sd8 <<< FRAC_BITS;
	localparam longint EXP_CAP  = (64'sd1 <<< 33) - 64'sd1;

	// method select codes
	typedef enum logic [1:0] {
		VAR_RAMP    = 2'd0,
		VAR_CLAMP   = 2'd1,
		VAR_LOGTAIL = 2'd2,
		VAR_NEWTON  = 2'd3
	} wo_variant_t;

	// side data that rides along with the divider
	typedef struct packed {
		logic signed [32:0] y;
		logic [30:0]        r_simple;
	} wo_tag_t;

	typedef struct packed {
		logic [DVD_W-1:0] dividend;
		logic [DEN_W-1:0] den;
		logic             neg;
		wo_tag_t          tag;
	} wo_divreq_t;

	typedef struct packed {
		logic [DVD_W-1:0] quot;
		logic             neg;
		wo_tag_t          tag;
	} wo_divres_t;

	// clamp to the unsigned 31-bit output range
	function automatic logic [30:0] sat31(input logic signed [59:0] v);
		if (v < 60'sd0)
			return '0;
		if (v > 60'sd2147483647)
			return '1;
		return v[30:0];
	endfunction

endpackage

`default_nettype wire

FILE: sv/wo_stream_if.sv
// wright omega approximation: valid/ready channels for samples and results
// depends on wo_pkg for nothing but kept after it in compile order
`default_nettype none

interface wo_x_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] x_value;

	modport source (output valid, output x_value, input ready);
	modport sink (input valid, input x_value, output ready);
endinterface

interface wo_omega_if;
	logic        valid;
	logic        ready;
	logic [30:0] omega_value;

	modport source (output valid, output omega_value, input ready);
	modport sink (input valid, input omega_value, output ready);
endinterface

`default_nettype wire

FILE: sv/wo_front.sv
// wright omega approximation: 13-stage front end, cubics, log tail, exp and divide setup
// depends on wo_pkg; feeds wo_div
`default_nettype none

module wo_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic signed [31:0]  x_value,
	input  wo_pkg::wo_variant_t variant,
	output logic                out_valid,
	output wo_pkg::wo_divreq_t  req
);
	import wo_pkg::*;

	localparam int NSTG = 13;

	localparam logic signed [31:0] TH1_LO = 32'(C1_X1_F);
	localparam logic signed [31:0] TH1_HI = 32'(C1_X2_F);
	localparam logic signed [31:0] TH2_LO = 32'(C2_X1_F);
	localparam logic signed [31:0] TH_8   = 32'(EIGHT_F);

	localparam logic signed [35:0] CA1 = 36'(C1_A);
	localparam logic signed [35:0] CB1 = 36'(C1_B);
	localparam logic signed [35:0] CC1 = 36'(C1_C);
	localparam logic signed [35:0] CD1 = 36'(C1_D);
	localparam logic signed [35:0] CA2 = 36'(C2_A);
	localparam logic signed [35:0] CB2 = 36'(C2_B);
	localparam logic signed [35:0] CC2 = 36'(C2_C);
	localparam logic signed [35:0] CD2 = 36'(C2_D);
	localparam logic signed [35:0] LK0 = 36'(LG_K0);
	localparam logic signed [35:0] LK1 = 36'(LG_K1);
	localparam logic signed [35:0] LK2 = 36'(LG_K2);
	localparam logic signed [35:0] LK3 = 36'(LG_K3);
	localparam logic signed [31:0] KLN2 = 32'(K_LN2);
	localparam logic signed [31:0] KL2E = 32'(K_LOG2E);
	localparam logic [31:0] PP1  = 32'(PW_P1);
	localparam logic [31:0] PP2  = 32'(PW_P2);
	localparam logic [31:0] PP3  = 32'(PW_P3);
	localparam logic [31:0] PONE = 32'(ONE30);
	localparam logic [33:0] ECAP = 34'(EXP_CAP);

	// signed product by the sample, rounded half up to Q30
	function automatic logic signed [35:0] mrx(input logic signed [35:0] a,
		input logic signed [27:0] b);
		logic signed [63:0] p;
		p = a * b;
		return 36'((p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
	endfunction

	// signed product by the log mantissa, rounded half up
	function automatic logic signed [35:0] mrm(input logic signed [35:0] a,
		input logic [30:0] m);
		logic signed [67:0] p;
		p = a * $signed({1'b0, m});
		return 36'((p + (68'sd1 <<< 29)) >>> 30);
	endfunction

	// unsigned product by the pow2 fraction, rounded half up
	function automatic logic [31:0] mru(input logic [31:0] a, input logic [29:0] f);
		logic [61:0] p;
		p = a * f;
		return 32'((p + (62'd1 << 29)) >> 30);
	endfunction

	logic [NSTG-1:0] v_s;

	// stage registers
	logic signed [31:0] x_s1, x_s2, x_s3, x_s4, x_s5, x_s6, x_s7;
	logic lt1_s1, lt1_s2, lt1_s3, lt1_s4, lt1_s5, lt1_s6;
	logic gt1_s1, gt1_s2, gt1_s3, gt1_s4, gt1_s5, gt1_s6;
	logic lt2_s1, lt2_s2, lt2_s3, lt2_s4, lt2_s5, lt2_s6;
	logic ge8_s1, ge8_s2, ge8_s3, ge8_s4, ge8_s5, ge8_s6;
	logic [1:0] pos_s1, pos_s2, pos_s3, pos_s4;
	logic [30:0] m_s1, m_s2, m_s3;
	logic signed [35:0] ca_s2, ca_s3, ca_s4;
	logic signed [35:0] cb_s2, cb_s3, cb_s4;
	logic signed [35:0] la_s2, la_s3, la_s4;
	logic signed [29:0] c1_s5, c1_s6, c2_s5, c2_s6, lg_s5;
	logic signed [31:0] ln_s6;
	logic signed [32:0] y_s7, y_s8, y_s9, y_s10, y_s11, y_s12;
	logic [30:0] rs_s7, rs_s8, rs_s9, rs_s10, rs_s11, rs_s12;
	logic signed [35:0] u_s8;
	logic signed [11:0] n_s9, n_s10, n_s11;
	logic [29:0] f_s9, f_s10;
	logic [31:0] ap_s9, ap_s10, ap_s11;
	logic [33:0] e_s12;
	wo_divreq_t req_s13;

	// combinational intermediates
	logic [1:0] pos_c;
	logic [30:0] m_c;
	logic signed [35:0] lgq_c;
	logic signed [61:0] lnp_c;
	logic signed [32:0] y_c, r_c;
	logic signed [33:0] t_c;
	logic signed [65:0] up_c;
	logic [29:0] f_c;
	logic [1:0] sh_up_c;
	logic [33:0] big_c, e_c;
	logic signed [12:0] sh_dn_c;
	logic signed [34:0] d_c;
	logic signed [33:0] den_c;
	logic [33:0] mag_c;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[NSTG-2:0], in_valid};
		end
	end

	// leading one and normalized mantissa for the log tail
	always_comb begin
		pos_c = x_value[30] ? 2'd3 : x_value[29] ? 2'd2 : x_value[28] ? 2'd1 : 2'd0;
		m_c   = 31'(x_value[30:0] << (2'd3 - pos_c));
	end

	// log2 in Q30 with the exponent folded in, and natural log product
	always_comb begin
		lgq_c = $signed({3'b000, 3'({1'b0, pos_s4} + 3'd3), 30'b0}) + la_s4;
		lnp_c = lg_s5 * KLN2;
	end

	// method 2 value and the simple methods
	always_comb begin
		if (lt2_s6)
			y_c = '0;
		else if (!ge8_s6)
			y_c = 33'(c2_s6);
		else
			y_c = 33'(x_s6) - 33'(ln_s6);
		case (variant)
			VAR_RAMP:    r_c = 33'(x_s6);
			VAR_CLAMP:   r_c = lt1_s6 ? '0 : (gt1_s6 ? 33'(x_s6) : 33'(c1_s6));
			VAR_LOGTAIL: r_c = y_c;
			default:     r_c = y_c;
		endcase
	end

	// exponent argument scaled to base 2
	always_comb begin
		t_c  = 34'(x_s7) - 34'(y_s7);
		up_c = t_c * KL2E;
		f_c  = {u_s8[FRAC_BITS-1:0], {FRAC_SH{1'b0}}};
	end

	// pow2 scaling with underflow and saturation
	always_comb begin
		sh_up_c = 2'(n_s11 - 12'(FRAC_SH));
		big_c   = {2'b00, ap_s11} << sh_up_c;
		sh_dn_c = 13'(FRAC_SH) - 13'(n_s11);
		if (n_s11 >= 12'(FRAC_SH + 3))
			e_c = ECAP;
		else if (n_s11 >= 12'(FRAC_SH))
			e_c = (big_c > ECAP) ? ECAP : big_c;
		else if (sh_dn_c >= 13'sd32)
			e_c = '0;
		else
			e_c = 34'(ap_s11 >> sh_dn_c[4:0]);
	end

	// newton numerator magnitude and divisor
	always_comb begin
		d_c   = 35'(y_s12) - $signed({1'b0, e_s12});
		mag_c = d_c[34] ? 34'(-d_c) : d_c[33:0];
		den_c = 34'(y_s12) + (34'sd1 <<< FRAC_BITS);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: compares and mantissa
			x_s1   <= x_value;
			lt1_s1 <= x_value < TH1_LO;
			gt1_s1 <= x_value > TH1_HI;
			lt2_s1 <= x_value < TH2_LO;
			ge8_s1 <= x_value >= TH_8;
			pos_s1 <= pos_c;
			m_s1   <= m_c;
			// s2..s4: horner steps of both cubics and the log polynomial
			ca_s2 <= CB1 + mrx(CA1, x_s1[27:0]);
			cb_s2 <= CB2 + mrx(CA2, x_s1[27:0]);
			la_s2 <= LK2 + mrm(LK3, m_s1);
			ca_s3 <= CC1 + mrx(ca_s2, x_s2[27:0]);
			cb_s3 <= CC2 + mrx(cb_s2, x_s2[27:0]);
			la_s3 <= LK1 + mrm(la_s2, m_s2);
			ca_s4 <= CD1 + mrx(ca_s3, x_s3[27:0]);
			cb_s4 <= CD2 + mrx(cb_s3, x_s3[27:0]);
			la_s4 <= LK0 + mrm(la_s3, m_s3);
			x_s2 <= x_s1; x_s3 <= x_s2; x_s4 <= x_s3; x_s5 <= x_s4; x_s6 <= x_s5;
			lt1_s2 <= lt1_s1; lt1_s3 <= lt1_s2; lt1_s4 <= lt1_s3;
			lt1_s5 <= lt1_s4; lt1_s6 <= lt1_s5;
			gt1_s2 <= gt1_s1; gt1_s3 <= gt1_s2; gt1_s4 <= gt1_s3;
			gt1_s5 <= gt1_s4; gt1_s6 <= gt1_s5;
			lt2_s2 <= lt2_s1; lt2_s3 <= lt2_s2; lt2_s4 <= lt2_s3;
			lt2_s5 <= lt2_s4; lt2_s6 <= lt2_s5;
			ge8_s2 <= ge8_s1; ge8_s3 <= ge8_s2; ge8_s4 <= ge8_s3;
			ge8_s5 <= ge8_s4; ge8_s6 <= ge8_s5;
			pos_s2 <= pos_s1; pos_s3 <= pos_s2; pos_s4 <= pos_s3;
			m_s2 <= m_s1; m_s3 <= m_s2;
			// s5: round to sample format
			c1_s5 <= 30'((ca_s4 + (36'sd1 <<< (FRAC_SH - 1))) >>> FRAC_SH);
			c2_s5 <= 30'((cb_s4 + (36'sd1 <<< (FRAC_SH - 1))) >>> FRAC_SH);
			lg_s5 <= 30'((lgq_c + (36'sd1 <<< (FRAC_SH - 1))) >>> FRAC_SH);
			// s6: natural log
			ln_s6 <= 32'((lnp_c + (62'sd1 <<< 29)) >>> 30);
			c1_s6 <= c1_s5;
			c2_s6 <= c2_s5;
			// s7: method select
			x_s7  <= x_s6;
			y_s7  <= y_c;
			rs_s7 <= sat31(60'(r_c));
			// s8: log2e scaling
			u_s8  <= 36'((up_c + (66'sd1 <<< 29)) >>> 30);
			y_s8  <= y_s7;
			rs_s8 <= rs_s7;
			// s9..s11: pow2 polynomial on the fraction
			n_s9  <= u_s8[35:FRAC_BITS];
			f_s9  <= f_c;
			ap_s9 <= PP2 + mru(PP3, f_c);
			n_s10  <= n_s9;
			f_s10  <= f_s9;
			ap_s10 <= PP1 + mru(ap_s9, f_s9);
			n_s11  <= n_s10;
			ap_s11 <= PONE + mru(ap_s10, f_s10);
			y_s9 <= y_s8; y_s10 <= y_s9; y_s11 <= y_s10; y_s12 <= y_s11;
			rs_s9 <= rs_s8; rs_s10 <= rs_s9; rs_s11 <= rs_s10; rs_s12 <= rs_s11;
			// s12: exp value
			e_s12 <= e_c;
			// s13: divider request
			req_s13.dividend   <= {mag_c, {FRAC_BITS{1'b0}}};
			req_s13.den        <= (den_c <= 34'sd0) ? 32'd1 : den_c[31:0];
			req_s13.neg        <= d_c[34];
			req_s13.tag.y      <= y_s12;
			req_s13.tag.r_simple <= rs_s12;
		end
	end

	assign out_valid = v_s[NSTG-1];
	assign req       = req_s13;

endmodule

`default_nettype wire

FILE: sv/wo_div.sv
// wright omega approximation: pipelined restoring divider, one quotient bit per stage
// depends on wo_pkg for widths and the request/result structs
`default_nettype none

module wo_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  wo_pkg::wo_divreq_t req,
	output logic               out_valid,
	output wo_pkg::wo_divres_t res
);
	import wo_pkg::*;

	logic [DVD_W-1:0] v_s;
	logic [DEN_W-1:0] rem_s [DVD_W];
	logic [DVD_W-1:0] dq_s [DVD_W];
	logic [DEN_W-1:0] den_s [DVD_W];
	logic             neg_s [DVD_W];
	wo_tag_t          tag_s [DVD_W];

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[DVD_W-2:0], in_valid};
		end
	end

	for (genvar i = 0; i < DVD_W; i++) begin : g_stage
		logic [DEN_W-1:0] rem_in;
		logic [DVD_W-1:0] dq_in;
		logic [DEN_W-1:0] den_in;
		logic             neg_in;
		wo_tag_t          tag_in;
		logic [DEN_W:0]   trial;
		logic             fits;

		if (i == 0) begin : g_first
			assign rem_in = '0;
			assign dq_in  = req.dividend;
			assign den_in = req.den;
			assign neg_in = req.neg;
			assign tag_in = req.tag;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign dq_in  = dq_s[i-1];
			assign den_in = den_s[i-1];
			assign neg_in = neg_s[i-1];
			assign tag_in = tag_s[i-1];
		end

		// shift in the next dividend bit and try the subtract
		assign trial = {rem_in, dq_in[DVD_W-1]};
		assign fits  = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= fits ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
				dq_s[i]  <= {dq_in[DVD_W-2:0], fits};
				den_s[i] <= den_in;
				neg_s[i] <= neg_in;
				tag_s[i] <= tag_in;
			end
		end
	end

	assign out_valid = v_s[DVD_W-1];

	always_comb begin
		res.quot = dq_s[DVD_W-1];
		res.neg  = neg_s[DVD_W-1];
		res.tag  = tag_s[DVD_W-1];
	end

endmodule

`default_nettype wire

FILE: sv/wright_omega_approximation.sv
// Wright omega approximation, one sample per clock while the skid entry is free. Results
// come out in order. The path runs through the 13-stage front end (cubics, log tail, exp)
// plus the 58-stage restoring divider for the Newton quotient, one final select stage and
// the output register; every variant takes the same path. A two-entry output buffer lets
// one more beat enter while a result waits, then sample.ready drops until result.ready
// returns. The variant register resets to the Newton method; the user must write it with
// cfg_we/cfg_wdata only while no beat is in flight, which the block does not enforce.
// depends on wo_pkg, wo_stream_if, wo_front and wo_div
`default_nettype none

module wright_omega_approximation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	wo_x_if.sink        sample,
	wo_omega_if.source  result
);
	import wo_pkg::*;

	wo_variant_t variant_q;
	logic        en;
	logic        front_valid;
	wo_divreq_t  front_req;
	logic        div_valid;
	wo_divres_t  div_res;

	logic        fin_valid_s;
	logic [30:0] fin_res_s;
	logic        out_valid_q;
	logic [30:0] out_data_q;
	logic        skid_valid_q;
	logic [30:0] skid_data_q;

	logic signed [59:0] q_c, r_c;
	logic [30:0]        fin_c;
	logic               arrive;

	// variant register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q <= VAR_NEWTON;
		end else if (cfg_we) begin
			variant_q <= wo_variant_t'(cfg_wdata);
		end
	end

	// the whole pipeline moves while the skid entry is free
	assign en           = !skid_valid_q;
	assign sample.ready = en;

	wo_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sample.valid),
		.x_value   (sample.x_value),
		.variant   (variant_q),
		.out_valid (front_valid),
		.req       (front_req)
	);

	wo_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (front_valid),
		.req       (front_req),
		.out_valid (div_valid),
		.res       (div_res)
	);

	// newton update and final select
	always_comb begin
		q_c   = $signed({2'b00, div_res.quot});
		r_c   = div_res.neg ? 60'(div_res.tag.y) + q_c : 60'(div_res.tag.y) - q_c;
		fin_c = (variant_q == VAR_NEWTON) ? sat31(r_c) : div_res.tag.r_simple;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_valid_s <= 1'b0;
		end else if (en) begin
			fin_valid_s <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_res_s <= fin_c;
		end
	end

	// output register with one skid entry
	assign arrive = en && fin_valid_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (result.ready || !out_valid_q) begin
			out_valid_q  <= skid_valid_q || arrive;
			skid_valid_q <= 1'b0;
		end else if (arrive) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (result.ready || !out_valid_q) begin
			out_data_q <= skid_valid_q ? skid_data_q : fin_res_s;
		end else if (arrive) begin
			skid_data_q <= fin_res_s;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.omega_value = out_data_q;

endmodule

`default_nettype wire

FILE: tb/tb_wright_omega_approximation.sv
// testbench for wright_omega_approximation: drives sample beats, predicts omega per variant
// and checks every result beat in order; depends on wo_pkg, wo_stream_if and the block
`default_nettype none

module tb_wright_omega_approximation;
	timeunit 1ns;
	timeprecision 1ps;
	import wo_pkg::*;

	// expected omega values and their predictor
	class omega_scoreboard;
		wo_variant_t   variant;
		longint        omega_q[$];
		int            mismatches;

		function new();
			variant    = VAR_NEWTON;
			mismatches = 0;
		endfunction

		function longint rnd_shift(longint v, int s);
			return (v + (64'sd1 <<< (s - 1))) >>> s;
		endfunction

		function longint mul_rnd(longint a, longint b, int s);
			return rnd_shift(a * b, s);
		endfunction

		function longint poly3(longint x, longint a, longint b, longint c, longint d);
			longint acc;
			acc = b + mul_rnd(a, x, FRAC_BITS);
			acc = c + mul_rnd(acc, x, FRAC_BITS);
			acc = d + mul_rnd(acc, x, FRAC_BITS);
			return rnd_shift(acc, FRAC_SH);
		endfunction

		// natural log via leading one position and mantissa cubic
		function longint nat_log(longint x);
			int     pos;
			longint m;
			longint acc;
			longint lg;
			pos = 30;
			while (pos > 0 && x[pos] == 1'b0)
				pos--;
			m   = x << (30 - pos);
			acc = LG_K2 + mul_rnd(LG_K3, m, 30);
			acc = LG_K1 + mul_rnd(acc, m, 30);
			acc = LG_K0 + mul_rnd(acc, m, 30);
			lg  = rnd_shift(longint'(pos - FRAC_BITS) * ONE30 + acc, FRAC_SH);
			return mul_rnd(lg, K_LN2, 30);
		endfunction

		// 2^u with underflow to zero and saturation
		function longint exp2_sat(longint u);
			longint n;
			longint f;
			longint acc;
			longint s;
			n   = u >>> FRAC_BITS;
			f   = (u & ((64'sd1 <<< FRAC_BITS) - 1)) << FRAC_SH;
			if (n < -126)
				return 0;
			acc = PW_P2 + mul_rnd(PW_P3, f, 30);
			acc = PW_P1 + mul_rnd(acc, f, 30);
			acc = ONE30 + mul_rnd(acc, f, 30);
			s   = n + FRAC_BITS - 30;
			if (s >= 3)
				return EXP_CAP;
			if (s >= 0) begin
				acc = acc << s;
				return (acc > EXP_CAP) ? EXP_CAP : acc;
			end
			if (-s >= 63)
				return 0;
			return acc >>> (-s);
		endfunction

		function longint log_tail(longint x);
			if (x < C2_X1_F)
				return 0;
			if (x < EIGHT_F)
				return poly3(x, C2_A, C2_B, C2_C, C2_D);
			return x - nat_log(x);
		endfunction

		function longint predict(logic signed [31:0] xs);
			longint x;
			longint r;
			longint y;
			longint e;
			longint den;
			x = xs;
			case (variant)
				VAR_RAMP: r = x;
				VAR_CLAMP: begin
					if (x < C1_X1_F)
						r = 0;
					else if (x > C1_X2_F)
						r = x;
					else
						r = poly3(x, C1_A, C1_B, C1_C, C1_D);
				end
				VAR_LOGTAIL: r = log_tail(x);
				default: begin
					y   = log_tail(x);
					e   = exp2_sat(mul_rnd(x - y, K_LOG2E, 30));
					den = y + (64'sd1 <<< FRAC_BITS);
					if (den <= 0)
						den = 1;
					r   = y - ((y - e) * (64'sd1 <<< FRAC_BITS)) / den;
				end
			endcase
			if (r < 0)
				r = 0;
			if (r > 64'sd2147483647)
				r = 64'sd2147483647;
			return r;
		endfunction

		function void note(logic signed [31:0] x);
			omega_q.push_back(predict(x));
		endfunction

		function void check(logic [30:0] got);
			longint want;
			if (omega_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: omega_value=%h", got);
				return;
			end
			want = omega_q.pop_front();
			if (longint'(got) != want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("omega mismatch: expected %h actual %h", want[30:0], got);
			end
		endfunction

		function int pending();
			return omega_q.size();
		endfunction
	endclass

	localparam int DRAIN_CYC = 100;
	localparam int STALL_LIMIT = 5000;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_wdata;
	bit         no_idle;
	int         quiet_cyc;
	omega_scoreboard sb;

	wo_x_if     sample();
	wo_omega_if result();

	wright_omega_approximation i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.sample    (sample.sink),
		.result    (result.source)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// beat monitor and watchdog
	always @(posedge clk) begin
		if (sample.valid && sample.ready)
			sb.note(sample.x_value);
		if (result.valid && result.ready)
			sb.check(result.omega_value);
		if ((sample.valid && sample.ready) || (result.valid && result.ready) || cfg_we)
			quiet_cyc <= 0;
		else
			quiet_cyc <= quiet_cyc + 1;
		if (quiet_cyc >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// result side: random stall before each beat
	initial begin
		int stall;
		result.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				result.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result.ready <= 1'b1;
			do @(posedge clk); while (!result.valid);
		end
	end

	task automatic send_sample(logic signed [31:0] x);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			sample.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample.valid   <= 1'b1;
		sample.x_value <= x;
		do @(posedge clk); while (!sample.ready);
	endtask

	task automatic wait_drained();
		sample.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic set_variant(wo_variant_t v);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we     <= 1'b0;
		sb.variant = v;
	endtask

	function automatic logic signed [31:0] rand_x();
		longint base;
		case ($urandom_range(0, 5))
			0, 1: return $urandom;
			2: return 32'(longint'($urandom_range(0, 14 << 24)) - (64'sd4 <<< 24));
			3: begin
				case ($urandom_range(0, 3))
					0: base = C1_X1_F;
					1: base = C1_X2_F;
					2: base = C2_X1_F;
					default: base = EIGHT_F;
				endcase
				return 32'(base + longint'($urandom_range(0, 32)) - 16);
			end
			4: return 32'(longint'($urandom_range(0, 32'h7fffffff)));
			default: return 32'(-longint'($urandom_range(0, 200 << 24)));
		endcase
	endfunction

	// stimulus
	initial begin
		logic signed [31:0] edge_x[$];
		wo_variant_t        vsel[4];
		sb             = new();
		no_idle        = 1'b0;
		quiet_cyc      = 0;
		arst_n         = 1'b0;
		cfg_we         <= 1'b0;
		cfg_wdata      <= '0;
		sample.valid   <= 1'b0;
		sample.x_value <= '0;
		repeat (8) @(posedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// field extremes, thresholds, log tail start, exp underflow and cap
		edge_x = '{32'sh80000000, 32'sh7fffffff, 32'sd0, -32'sd1, 32'sd1,
			32'(C1_X1_F), 32'(C1_X1_F - 1), 32'(C1_X2_F), 32'(C1_X2_F + 1),
			32'(C2_X1_F), 32'(C2_X1_F - 1), 32'(EIGHT_F - 1), 32'(EIGHT_F),
			32'sd1 <<< 24, -(32'sd1 <<< 24), 32'sd5 <<< 24,
			32'sd20 <<< 24, 32'sd100 <<< 24, -(32'sd20 <<< 24), -(32'sd88 <<< 24),
			32'sh40000000};
		vsel = '{VAR_NEWTON, VAR_RAMP, VAR_CLAMP, VAR_LOGTAIL};
		foreach (vsel[i]) begin
			set_variant(vsel[i]);
			foreach (edge_x[j])
				send_sample(edge_x[j]);
		end

		// random phases, some without idling, one paused until drained
		for (int ph = 0; ph < 8; ph++) begin
			set_variant(wo_variant_t'(ph < 4 ? (3 - ph) : $urandom_range(0, 3)));
			no_idle = (ph % 3 == 2);
			for (int k = 0; k < 100; k++) begin
				if (ph == 5 && k == 50)
					wait_drained();
				send_sample(rand_x());
			end
			no_idle = 1'b0;
		end

		wait_drained();
		if (sb.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
